>>> sv/lpt_pkg.sv
// Package: shared types, codes and constants for the link peer table.
`default_nettype none
package lpt_pkg;

  localparam int LPT_ENTRIES = 16;
  localparam int ADDR_W      = 48;
  localparam int HANDLE_W    = 16;
  localparam int SLOT_W      = 4;

  localparam logic [HANDLE_W-1:0] NO_HANDLE = 16'hFFFF;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_REMOVE     = 3'd1,
    OP_CONNECT    = 3'd2,
    OP_DISCONNECT = 3'd3,
    OP_DISCOVERY  = 3'd4,
    OP_PENDING    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    LS_INIT         = 2'd0,
    LS_CONNECTED    = 2'd1,
    LS_DISCONNECTED = 2'd2
  } lstate_t;

  typedef enum logic [1:0] {
    RC_DONE     = 2'd0,
    RC_PRESENT  = 2'd1,
    RC_FULL     = 2'd2,
    RC_NO_MATCH = 2'd3
  } code_t;

  // Command token handed from cell to cell.
  typedef struct packed {
    logic                valid;
    logic                done;
    logic                have_free;
    op_t                 op;
    logic [ADDR_W-1:0]   addr;
    logic                role;
    logic [HANDLE_W-1:0] handle;
    logic                failed;
    code_t               code;
  } token_t;

  // Broadcast write that fills a free entry on an add.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic              role;
  } wr_t;

endpackage
`default_nettype wire

>>> sv/lpt_if.sv
// Interfaces: request and response channels of the link peer table.
`default_nettype none
interface lpt_req_if import lpt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [2:0]          op;
  logic [ADDR_W-1:0]   peer_address;
  logic                role;
  logic [HANDLE_W-1:0] link_handle;
  logic                connect_failed;

  modport source (output valid, op, peer_address, role, link_handle, connect_failed,
                  input ready);
  modport sink   (input valid, op, peer_address, role, link_handle, connect_failed,
                  output ready);
endinterface

interface lpt_rsp_if import lpt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        result_code;
  logic              hit;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, result_code, hit, slot, input ready);
  modport sink   (input valid, result_code, hit, slot, output ready);
endinterface
`default_nettype wire

>>> sv/lpt_cell.sv
// Cell: one table entry plus one stage of the command token chain.
`default_nettype none
module lpt_cell import lpt_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  token_t           tok_in,
  input  logic [IDX_W-1:0] slot_in,
  input  logic [IDX_W-1:0] free_in,
  output token_t           tok_out,
  output logic [IDX_W-1:0] slot_out,
  output logic [IDX_W-1:0] free_out,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] wr_slot
);

  localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(INDEX);

  logic                used;
  logic [ADDR_W-1:0]   address;
  logic                role;
  logic [HANDLE_W-1:0] handle;
  lstate_t             link_state;

  logic   active, addr_eq, role_eq, conn, match, take_free, wr_hit;
  token_t tok_next;

  assign active  = tok_in.valid && !tok_in.done;
  assign addr_eq = used && (address == tok_in.addr);
  assign role_eq = (role == tok_in.role);
  assign conn    = (link_state == LS_CONNECTED);
  assign wr_hit  = wr.en && (wr_slot == MY_SLOT);

  always_comb begin
    case (tok_in.op)
      OP_ADD:        match = addr_eq;
      OP_REMOVE:     match = addr_eq;
      OP_CONNECT:    match = !tok_in.failed && addr_eq && role_eq && !conn;
      OP_DISCONNECT: match = used && role_eq && conn && (handle == tok_in.handle);
      OP_DISCOVERY:  match = addr_eq && role && !conn;
      OP_PENDING:    match = used && role_eq && !conn;
      default:       match = 1'b0;
    endcase
  end

  // Remember the lowest free entry for a later fill.
  assign take_free = active && (tok_in.op == OP_ADD) && !used && !tok_in.have_free;

  always_comb begin
    tok_next = tok_in;
    if (active && match) begin
      tok_next.done = 1'b1;
      tok_next.code = (tok_in.op == OP_ADD) ? RC_PRESENT : RC_DONE;
    end
    if (take_free) begin
      tok_next.have_free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.done      <= tok_next.done;
    tok_out.have_free <= tok_next.have_free;
    tok_out.op        <= tok_next.op;
    tok_out.addr      <= tok_next.addr;
    tok_out.role      <= tok_next.role;
    tok_out.handle    <= tok_next.handle;
    tok_out.failed    <= tok_next.failed;
    tok_out.code      <= tok_next.code;
    slot_out          <= (active && match) ? MY_SLOT : slot_in;
    free_out          <= take_free ? MY_SLOT : free_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (wr_hit) begin
      used <= 1'b1;
    end else if (active && match && (tok_in.op == OP_REMOVE)) begin
      used <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      address    <= wr.addr;
      role       <= wr.role;
      handle     <= NO_HANDLE;
      link_state <= LS_INIT;
    end else if (active && match) begin
      case (tok_in.op)
        OP_REMOVE, OP_DISCONNECT: begin
          handle     <= NO_HANDLE;
          link_state <= LS_DISCONNECTED;
        end
        OP_CONNECT: begin
          handle     <= tok_in.handle;
          link_state <= LS_CONNECTED;
        end
        default: begin
          handle <= handle;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sv/link_peer_table_core.sv
// Top level: link peer table, a row of entry cells walked by a command token.
//
// Usage: requests arrive on the req channel (valid/ready), one operation per
// item: add, remove, connect event, disconnect event, discovery or pending
// query. Each request yields exactly one item on the rsp channel carrying a
// result code, a hit flag and the slot of the entry touched or found.
//
// Flow: an accepted item enters cell 0 at once and walks one cell per
// cycle through the chain of ENTRIES cells; its result is registered in
// a holding stage, then moved to the output register. One item is in the
// chain at a time, so a new item is accepted only once the last result
// has left the holding stage. An add that fills a free entry writes it in
// the cycle the token leaves the last cell.
//
// Reset (rst, synchronous, active high): all entries are freed, the chain
// is emptied and the output valid flag is cleared; no reset pass is needed.
//
// Stalls: the response sits in an output register until rsp.ready is high.
// The next request is accepted and walks the chain meanwhile; its result
// then waits in a holding stage until the output register frees up.
`default_nettype none
module link_peer_table_core import lpt_pkg::*; #(
  parameter int ENTRIES = LPT_ENTRIES
) (
  input  logic     clk,
  input  logic     rst,
  lpt_req_if.sink  req,
  lpt_rsp_if.source rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state, state_next;

  token_t           tok  [ENTRIES+1];
  logic [IDX_W-1:0] tslot[ENTRIES+1];
  logic [IDX_W-1:0] fslot[ENTRIES+1];

  token_t           last;
  wr_t              wr;
  logic [IDX_W-1:0] wr_slot;

  code_t            res_code, fin_code;
  logic             res_hit, fin_hit;
  logic [IDX_W-1:0] res_slot, fin_slot;
  logic [31:0]      slot_wide;

  logic out_valid, out_free, accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign out_free  = !out_valid || rsp.ready;

  // Inject the request as a fresh token into cell 0.
  always_comb begin
    tok[0].valid     = accept;
    tok[0].done      = 1'b0;
    tok[0].have_free = 1'b0;
    tok[0].op        = op_t'(req.op);
    tok[0].addr      = req.peer_address;
    tok[0].role      = req.role;
    tok[0].handle    = req.link_handle;
    tok[0].failed    = req.connect_failed;
    tok[0].code      = RC_NO_MATCH;
  end
  assign tslot[0] = '0;
  assign fslot[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lpt_cell #(
      .IDX_W (IDX_W),
      .INDEX (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok[g]),
      .slot_in  (tslot[g]),
      .free_in  (fslot[g]),
      .tok_out  (tok[g+1]),
      .slot_out (tslot[g+1]),
      .free_out (fslot[g+1]),
      .wr       (wr),
      .wr_slot  (wr_slot)
    );
  end

  assign last = tok[ENTRIES];

  // Settle the outcome as the token leaves the last cell.
  always_comb begin
    fin_code = RC_NO_MATCH;
    fin_hit  = 1'b0;
    fin_slot = '0;
    if (last.done) begin
      fin_code = last.code;
      fin_hit  = 1'b1;
      fin_slot = tslot[ENTRIES];
    end else if (last.op == OP_ADD) begin
      if (last.have_free) begin
        fin_code = RC_DONE;
        fin_hit  = 1'b1;
        fin_slot = fslot[ENTRIES];
      end else begin
        fin_code = RC_FULL;
      end
    end
  end

  // Fill the lowest free entry on an add with no duplicate.
  assign wr.en   = last.valid && (last.op == OP_ADD) && !last.done && last.have_free;
  assign wr.addr = last.addr;
  assign wr.role = last.role;
  assign wr_slot = fslot[ENTRIES];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept)     state_next = ST_SCAN;
      ST_SCAN: if (last.valid) state_next = ST_HOLD;
      ST_HOLD: if (out_free)   state_next = ST_IDLE;
      default:                 state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the settled result until the output register frees up.
  always_ff @(posedge clk) begin
    if (last.valid) begin
      res_code <= fin_code;
      res_hit  <= fin_hit;
      res_slot <= fin_slot;
    end
  end

  assign slot_wide = 32'(res_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      rsp.result_code <= res_code;
      rsp.hit         <= res_hit;
      rsp.slot        <= slot_wide[SLOT_W-1:0];
    end
  end

  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

>>> dv/tb_link_peer_table_core.sv
// Testbench: link peer table core, checked item by item against a scoreboard model.
`timescale 1ns / 100ps
`default_nettype none
module tb_link_peer_table_core;
  import lpt_pkg::*;

  localparam int N_ENTRIES  = LPT_ENTRIES;
  localparam int ADDR_POOL  = 24;       // more addresses than entries, so the table fills
  localparam int HNDL_POOL  = 8;
  localparam int STALL_MAX  = 2000;     // cycles with no item moving on either channel
  localparam int MAX_REPORT = 10;

  // One expected answer of the table.
  typedef struct packed {
    code_t             code;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } peer_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lpt_req_if req_ch ();
  lpt_rsp_if rsp_ch ();

  link_peer_table_core #(
    .ENTRIES (N_ENTRIES)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 8 ns period.
  always #4 clk = ~clk;

  // Shadow copy of the peer table, advanced once per accepted request.
  logic                e_used   [N_ENTRIES];
  logic [ADDR_W-1:0]   e_addr   [N_ENTRIES];
  logic                e_role   [N_ENTRIES];
  logic [HANDLE_W-1:0] e_handle [N_ENTRIES];
  lstate_t             e_state  [N_ENTRIES];

  peer_rsp_t           expected_rsp_q [$];

  logic [ADDR_W-1:0]   addr_pool [ADDR_POOL];
  logic [HANDLE_W-1:0] hndl_pool [HNDL_POOL];
  logic [ADDR_W-1:0]   dir_addr  [N_ENTRIES];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int n_errors    = 0;
  int n_reported  = 0;

  // Work out the answer to one request and advance the shadow table.
  // Every scan runs from slot 0 upward and stops at the first entry that qualifies.
  function automatic peer_rsp_t lookup_peer(input logic [2:0]          op,
                                            input logic [ADDR_W-1:0]   addr,
                                            input logic                role,
                                            input logic [HANDLE_W-1:0] handle,
                                            input logic                failed);
    peer_rsp_t r;
    bit        found;
    r     = '{code: RC_NO_MATCH, hit: 1'b0, slot: '0};
    found = 1'b0;
    case (op)
      OP_ADD: begin
        // Duplicate check ignores role.
        for (int i = 0; i < N_ENTRIES && !found; i++) begin
          if (e_used[i] && e_addr[i] == addr) begin
            r     = '{code: RC_PRESENT, hit: 1'b1, slot: SLOT_W'(i)};
            found = 1'b1;
          end
        end
        for (int i = 0; i < N_ENTRIES && !found; i++) begin
          if (!e_used[i]) begin
            e_used[i]   = 1'b1;
            e_addr[i]   = addr;
            e_role[i]   = role;
            e_handle[i] = NO_HANDLE;
            e_state[i]  = LS_INIT;
            r           = '{code: RC_DONE, hit: 1'b1, slot: SLOT_W'(i)};
            found       = 1'b1;
          end
        end
        if (!found) r = '{code: RC_FULL, hit: 1'b0, slot: '0};
      end
      OP_REMOVE: begin
        for (int i = 0; i < N_ENTRIES && !found; i++) begin
          if (e_used[i] && e_addr[i] == addr) begin
            e_used[i]   = 1'b0;
            e_handle[i] = NO_HANDLE;
            e_state[i]  = LS_DISCONNECTED;
            r           = '{code: RC_DONE, hit: 1'b1, slot: SLOT_W'(i)};
            found       = 1'b1;
          end
        end
      end
      OP_CONNECT: begin
        // A failed connect leaves the table alone.
        for (int i = 0; i < N_ENTRIES && !found && !failed; i++) begin
          if (e_used[i] && e_role[i] == role && e_state[i] != LS_CONNECTED &&
              e_addr[i] == addr) begin
            e_handle[i] = handle;
            e_state[i]  = LS_CONNECTED;
            r           = '{code: RC_DONE, hit: 1'b1, slot: SLOT_W'(i)};
            found       = 1'b1;
          end
        end
      end
      OP_DISCONNECT: begin
        for (int i = 0; i < N_ENTRIES && !found; i++) begin
          if (e_used[i] && e_role[i] == role && e_state[i] == LS_CONNECTED &&
              e_handle[i] == handle) begin
            e_handle[i] = NO_HANDLE;
            e_state[i]  = LS_DISCONNECTED;
            r           = '{code: RC_DONE, hit: 1'b1, slot: SLOT_W'(i)};
            found       = 1'b1;
          end
        end
      end
      OP_DISCOVERY: begin
        // Only unconnected slave entries answer; the role field plays no part.
        for (int i = 0; i < N_ENTRIES && !found; i++) begin
          if (e_used[i] && e_role[i] && e_addr[i] == addr && e_state[i] != LS_CONNECTED) begin
            r     = '{code: RC_DONE, hit: 1'b1, slot: SLOT_W'(i)};
            found = 1'b1;
          end
        end
      end
      OP_PENDING: begin
        for (int i = 0; i < N_ENTRIES && !found; i++) begin
          if (e_used[i] && e_state[i] != LS_CONNECTED && e_role[i] == role) begin
            r     = '{code: RC_DONE, hit: 1'b1, slot: SLOT_W'(i)};
            found = 1'b1;
          end
        end
      end
      default: ;  // unused op codes: no match, nothing changes
    endcase
    return r;
  endfunction

  // Send one request item. Call just after a rising edge; returns just after the
  // edge at which the item is taken. Valid is left high so that back-to-back items
  // see no gap; the caller or the next idle stretch lowers it.
  task automatic send_item(input logic [2:0]          op,
                           input logic [ADDR_W-1:0]   addr,
                           input logic                role,
                           input logic [HANDLE_W-1:0] handle,
                           input logic                failed);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.op             <= op;
    req_ch.peer_address   <= addr;
    req_ch.role           <= role;
    req_ch.link_handle    <= handle;
    req_ch.connect_failed <= failed;
    // Sample mid-cycle, away from the edge where the block updates.
    do @(negedge clk); while (!req_ch.ready);
    expected_rsp_q.push_back(lookup_peer(op, addr, role, handle, failed));
    @(posedge clk);
  endtask

  // Empty table: every lookup misses, unused codes answer no match.
  task automatic test_empty_table();
    send_item(OP_PENDING, '0, 1'b1, '0, 1'b0);
    send_item(OP_REMOVE, '1, 1'b0, '1, 1'b1);
    send_item(3'd7, '1, 1'b1, '1, 1'b1);
  endtask

  // Fill every slot, hit the duplicate check, then overflow the table.
  task automatic test_fill_table();
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (i == 0)
        dir_addr[i] = '0;
      else if (i == N_ENTRIES - 1)
        dir_addr[i] = '1;
      else
        dir_addr[i] = ADDR_W'({$urandom, $urandom});
      send_item(OP_ADD, dir_addr[i], i[0], HANDLE_W'($urandom), 1'b0);
    end
    // Duplicate with the other role still counts as present.
    send_item(OP_ADD, dir_addr[5], 1'b0, '0, 1'b0);
    send_item(OP_ADD, ADDR_W'({$urandom, $urandom}), 1'b1, '1, 1'b0);
  endtask

  // Connect, discovery, pending and disconnect on the full table, then free a slot.
  task automatic test_link_events();
    send_item(OP_CONNECT, dir_addr[1], 1'b1, 16'h1234, 1'b1);    // failed connect
    send_item(OP_CONNECT, dir_addr[1], 1'b1, NO_HANDLE, 1'b0);
    send_item(OP_DISCOVERY, dir_addr[3], 1'b0, '0, 1'b0);
    send_item(OP_DISCOVERY, dir_addr[1], 1'b1, '0, 1'b0);        // now connected: miss
    send_item(OP_PENDING, '1, 1'b0, '1, 1'b0);
    send_item(OP_DISCONNECT, '0, 1'b1, NO_HANDLE, 1'b0);
    send_item(OP_REMOVE, dir_addr[0], 1'b1, '0, 1'b0);
  endtask

  // Mostly well-formed traffic over a small pool of peers, so that adds collide,
  // connects find their entries and disconnects find their handles; the rest is
  // noise with fresh addresses, stray handles and unused op codes.
  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    int                  w;
    int                  s;
    logic [2:0]          op;
    logic [ADDR_W-1:0]   a;
    logic                r;
    logic [HANDLE_W-1:0] h;
    logic                f;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < n_items; k++) begin
      w = $urandom_range(99);
      s = $urandom_range(N_ENTRIES - 1);
      a = addr_pool[$urandom_range(ADDR_POOL - 1)];
      r = 1'($urandom_range(1));
      h = hndl_pool[$urandom_range(HNDL_POOL - 1)];
      f = ($urandom_range(9) == 0);
      if (w < 24) begin
        op = OP_ADD;
      end else if (w < 42) begin
        op = OP_REMOVE;
        if (e_used[s] && $urandom_range(1)) a = e_addr[s];
      end else if (w < 62) begin
        op = OP_CONNECT;
        if (e_used[s] && $urandom_range(3) != 0) begin
          a = e_addr[s];
          r = e_role[s];
        end
      end else if (w < 77) begin
        op = OP_DISCONNECT;
        if (e_used[s] && e_state[s] == LS_CONNECTED && $urandom_range(3) != 0) begin
          r = e_role[s];
          h = e_handle[s];
        end
      end else if (w < 86) begin
        op = OP_DISCOVERY;
      end else if (w < 95) begin
        op = OP_PENDING;
      end else begin
        op = 3'($urandom_range(7, 6));
      end
      if ($urandom_range(9) == 0) a = ADDR_W'({$urandom, $urandom});
      if ($urandom_range(9) == 0) h = HANDLE_W'($urandom);
      send_item(op, a, r, h, f);
    end
  endtask

  // Receiver: drop ready at the rate set for the current phase.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Checker: compare each response taken with the oldest expected answer.
  initial begin : rsp_check
    peer_rsp_t want;
    bit        bad;
    forever begin
      @(negedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          n_errors++;
          if (n_reported < MAX_REPORT) begin
            n_reported++;
            $display("unexpected response: code %0d hit %0d slot %0d",
                     rsp_ch.result_code, rsp_ch.hit, rsp_ch.slot);
          end
        end else begin
          want = expected_rsp_q.pop_front();
          bad  = (rsp_ch.result_code !== want.code) || (rsp_ch.hit !== want.hit) ||
                 (rsp_ch.slot !== want.slot);
          if (bad) begin
            n_errors++;
            if (n_reported < MAX_REPORT) begin
              n_reported++;
              $display("response mismatch: expected code %0d hit %0d slot %0d,",
                       want.code, want.hit, want.slot,
                       " got code %0d hit %0d slot %0d",
                       rsp_ch.result_code, rsp_ch.hit, rsp_ch.slot);
            end
          end
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves an item for too long.
  initial begin : stall_watch
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(negedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed checks, then three random phases.
  initial begin
    req_ch.valid          = 1'b0;
    req_ch.op             = OP_ADD;
    req_ch.peer_address   = '0;
    req_ch.role           = 1'b0;
    req_ch.link_handle    = '0;
    req_ch.connect_failed = 1'b0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      e_used[i]   = 1'b0;
      e_addr[i]   = '0;
      e_role[i]   = 1'b0;
      e_handle[i] = '0;
      e_state[i]  = LS_INIT;
    end
    // Keep the extremes in the pool so that they keep turning up.
    for (int i = 0; i < ADDR_POOL; i++) addr_pool[i] = ADDR_W'({$urandom, $urandom});
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 0; i < HNDL_POOL; i++) hndl_pool[i] = HANDLE_W'($urandom);
    hndl_pool[0] = '0;
    hndl_pool[1] = NO_HANDLE;

    // Hold reset at the start, once only.
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_fill_table();
    test_link_events();
    test_random_traffic(600, 18, 79);
    test_random_traffic(600, 79, 18);
    test_random_traffic(600, 0, 0);
    req_ch.valid <= 1'b0;

    // Drain, then give any stray response time to show up.
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (2 * N_ENTRIES + 8) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
